// File: hw/rtl/paged_rom_board_with_command_latch_unit_macros.svh
// assertion macros used by the paged rom board controller
`ifndef PAGED_ROM_BOARD_WITH_COMMAND_LATCH_UNIT_MACROS_SVH
`define PAGED_ROM_BOARD_WITH_COMMAND_LATCH_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PRB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PRB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) else $error(msg);
`else
`define PRB_ASSERT(lbl, prop, msg)
`define PRB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: hw/rtl/prb_pkg.sv
// shared types and constants of the paged rom board
package prb_pkg;

  localparam int NUM_BANKS_DEF = 12;
  localparam int ROM_BYTES     = 16384;
  localparam int ROM_AW        = 14;
  localparam int BYTE_W        = 8;
  localparam int IN_TDATA_W    = 32;
  localparam int IN_TUSER_W    = 2;
  localparam int OUT_TDATA_W   = 16;

  // latch byte codes
  localparam logic [7:0] PREFIX_BYTE   = 8'hFC;
  localparam logic [7:0] IGN_FIRST     = 8'hFD;
  localparam logic [7:0] IGN_LAST      = 8'hFF;
  localparam logic [7:0] CMD_NOP       = 8'h00;
  localparam logic [7:0] CMD_SIMPLE_A  = 8'h01;
  localparam logic [7:0] CMD_SIMPLE_B  = 8'h02;
  localparam logic [7:0] CMD_SIMPLE_C  = 8'h07;
  localparam logic [7:0] CMD_SIMPLE_D  = 8'h08;
  localparam logic [7:0] CMD_BANK_IN   = 8'h10;
  localparam logic [7:0] CMD_BANK_OUT  = 8'h11;
  localparam logic [7:0] CMD_LED       = 8'hFE;
  localparam logic [7:0] CMD_OPT_RESET = 8'hFA;
  localparam logic [7:0] CMD_OPT_LOAD  = 8'hFD;
  localparam logic [7:0] CMD_OPT_SAVE  = 8'hFC;
  localparam logic [7:0] CMD_USB       = 8'hFF;

  localparam logic [ROM_AW-1:0] RESP_OFFSET   = 14'h3F00;
  localparam logic [ROM_AW-1:0] STATUS_OFFSET = 14'h3F01;
  localparam logic [7:0]        ERASED_BYTE   = 8'hFF;
  localparam logic [7:0]        STATUS_OK     = 8'h00;

  typedef enum logic [1:0] {
    MODE_READ,
    MODE_LATCH,
    MODE_LOAD,
    MODE_NOP
  } mode_e;

  typedef enum logic [1:0] {
    PHASE_IDLE,
    PHASE_PREFIX,
    PHASE_PARAMS
  } phase_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_FILL,
    S_STATUS,
    S_BUMP_RD,
    S_BUMP_WR,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ITEM,
    OP_CLEAR,
    OP_FILL,
    OP_STATUS,
    OP_BUMP_RD,
    OP_BUMP_WR
  } mem_op_e;

  typedef struct packed {
    mem_op_e op;
    logic    cnt_clr;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  act_fill;
    logic  act_status;
    logic  act_bump;
    logic  cnt_last_all;
    logic  cnt_last_bank;
  } dp_status_t;

endpackage

// File: hw/rtl/prb_ram.sv
// generic single-port ram with registered read
module prb_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16384,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/prb_datapath.sv
// datapath: rom stores, latch protocol registers, sweep counter, result register
module prb_datapath #(
  parameter int NUM_BANKS = prb_pkg::NUM_BANKS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  prb_pkg::dp_cmd_t                    cmd_i,
  output prb_pkg::dp_status_t                 status_o,
  input  logic [prb_pkg::IN_TDATA_W-1:0]      s_tdata_i,
  input  logic [prb_pkg::IN_TUSER_W-1:0]      s_tuser_i,
  output logic [prb_pkg::OUT_TDATA_W-1:0]     m_tdata_o
);

  localparam int BANK_W   = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
  localparam int UP_DEPTH = NUM_BANKS * prb_pkg::ROM_BYTES;
  localparam int UP_AW    = $clog2(UP_DEPTH);
  localparam int ROM_AW   = prb_pkg::ROM_AW;
  localparam logic [UP_AW-1:0]  LAST_ALL  = UP_AW'(UP_DEPTH - 1);
  localparam logic [ROM_AW-1:0] LAST_OFF  = ROM_AW'(prb_pkg::ROM_BYTES - 1);
  localparam logic [BANK_W-1:0] TOP_BANK  = BANK_W'(NUM_BANKS - 1);
  localparam logic [7:0]        NB_BYTE   = 8'(NUM_BANKS);
  localparam logic [4:0]        NB_NIBBLE = 5'(NUM_BANKS);

  function automatic logic [UP_AW-1:0] up_at(input logic [BANK_W-1:0] b,
                                             input logic [ROM_AW-1:0] o);
    up_at = UP_AW'({b, o});
  endfunction

  function automatic logic [BANK_W-1:0] clamp_bank(input logic [7:0] v);
    clamp_bank = (v >= NB_BYTE) ? TOP_BANK : v[BANK_W-1:0];
  endfunction

  // input fields
  prb_pkg::mode_e    mode;
  logic              romen_n;
  logic              a15;
  logic [ROM_AW-1:0] addr;
  logic [7:0]        din;
  logic              ld_up;
  logic [3:0]        ld_bank;

  assign mode    = prb_pkg::mode_e'(s_tuser_i);
  assign romen_n = s_tdata_i[0];
  assign a15     = s_tdata_i[1];
  assign addr    = s_tdata_i[15:2];
  assign din     = s_tdata_i[23:16];
  assign ld_up   = s_tdata_i[24];
  assign ld_bank = s_tdata_i[28:25];

  // latch protocol and board state
  prb_pkg::phase_e       phase_q, phase_d;
  logic [7:0]            pending_q, pending_d;
  logic [1:0]            left_q, left_d;
  logic [BANK_W-1:0]     sel_q, sel_d;
  logic                  lamp_q, lamp_d;
  logic [NUM_BANKS-1:0]  present_q, present_d;
  logic [BANK_W-1:0]     fill_bank_q, fill_bank_d;
  logic [UP_AW-1:0]      cnt_q, cnt_d;
  logic                  act_fill, act_status, act_bump;

  logic item_en;
  logic is_read;
  logic is_load;
  logic latch_en;
  logic ld_ok;

  assign item_en  = (cmd_i.op == prb_pkg::OP_ITEM);
  assign is_read  = (mode == prb_pkg::MODE_READ) && !romen_n;
  assign is_load  = (mode == prb_pkg::MODE_LOAD);
  assign latch_en = item_en && (mode == prb_pkg::MODE_LATCH);
  assign ld_ok    = {1'b0, ld_bank} < NB_NIBBLE;

  always_comb begin
    logic [1:0] left_n;
    phase_d     = phase_q;
    pending_d   = pending_q;
    left_d      = left_q;
    sel_d       = sel_q;
    lamp_d      = lamp_q;
    present_d   = present_q;
    fill_bank_d = fill_bank_q;
    act_fill    = 1'b0;
    act_status  = 1'b0;
    act_bump    = 1'b0;
    left_n      = left_q;

    case (phase_q)
      prb_pkg::PHASE_IDLE: begin
        if (din == prb_pkg::PREFIX_BYTE) begin
          phase_d = prb_pkg::PHASE_PREFIX;
        end else if (din inside {[prb_pkg::IGN_FIRST:prb_pkg::IGN_LAST]}) begin
          sel_d = sel_q;
        end else begin
          sel_d = (din >= NB_BYTE) ? '0 : din[BANK_W-1:0];
        end
      end
      prb_pkg::PHASE_PREFIX: begin
        pending_d = din;
        left_d    = 2'd0;
        phase_d   = prb_pkg::PHASE_PARAMS;
        case (din)
          prb_pkg::CMD_NOP: begin
            phase_d = prb_pkg::PHASE_IDLE;
          end
          prb_pkg::CMD_SIMPLE_A, prb_pkg::CMD_SIMPLE_B, prb_pkg::CMD_SIMPLE_C,
          prb_pkg::CMD_SIMPLE_D, prb_pkg::CMD_USB: begin
            act_bump  = 1'b1;
            phase_d   = prb_pkg::PHASE_IDLE;
            pending_d = '0;
          end
          prb_pkg::CMD_BANK_IN: begin
            left_d = 2'd2;
          end
          prb_pkg::CMD_BANK_OUT, prb_pkg::CMD_LED, prb_pkg::CMD_OPT_LOAD,
          prb_pkg::CMD_OPT_SAVE, prb_pkg::CMD_OPT_RESET: begin
            left_d = 2'd1;
          end
          default: begin
            // unknown command: the next byte is swallowed
            left_d = 2'd0;
          end
        endcase
      end
      default: begin
        if (left_q != 2'd0) begin
          left_n = left_q - 2'd1;
        end
        left_d = left_n;
        if (left_n == 2'd0) begin
          case (pending_q)
            prb_pkg::CMD_BANK_IN: begin
              present_d[clamp_bank(din)] = 1'b1;
              act_bump = 1'b1;
            end
            prb_pkg::CMD_BANK_OUT: begin
              present_d[clamp_bank(din)] = 1'b0;
              fill_bank_d = clamp_bank(din);
              act_fill = 1'b1;
              act_bump = 1'b1;
            end
            prb_pkg::CMD_LED: begin
              lamp_d     = (din != 8'h00);
              act_status = 1'b1;
              act_bump   = 1'b1;
            end
            prb_pkg::CMD_OPT_RESET: begin
              act_status = 1'b1;
              act_bump   = 1'b1;
            end
            prb_pkg::CMD_OPT_LOAD, prb_pkg::CMD_OPT_SAVE: begin
              act_bump = 1'b1;
            end
            default: begin
              act_bump = 1'b0;
            end
          endcase
          phase_d   = prb_pkg::PHASE_IDLE;
          pending_d = '0;
          left_d    = 2'd0;
        end
      end
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.op == prb_pkg::OP_CLEAR || cmd_i.op == prb_pkg::OP_FILL) begin
      cnt_d = cnt_q + UP_AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= prb_pkg::PHASE_IDLE;
      pending_q   <= '0;
      left_q      <= '0;
      sel_q       <= '0;
      lamp_q      <= 1'b0;
      present_q   <= '0;
      fill_bank_q <= '0;
      cnt_q       <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (latch_en) begin
        phase_q     <= phase_d;
        pending_q   <= pending_d;
        left_q      <= left_d;
        sel_q       <= sel_d;
        lamp_q      <= lamp_d;
        present_q   <= present_d;
        fill_bank_q <= fill_bank_d;
      end else if (item_en && is_load && ld_up && ld_ok) begin
        present_q[ld_bank[BANK_W-1:0]] <= 1'b1;
      end
    end
  end

  // store ports
  logic              up_we, up_re;
  logic [UP_AW-1:0]  up_addr;
  logic [7:0]        up_wdata, up_rdata;
  logic              lo_we, lo_re;
  logic [7:0]        lo_rdata;

  always_comb begin
    up_we    = 1'b0;
    up_re    = 1'b0;
    up_addr  = up_at(sel_q, addr);
    up_wdata = din;
    lo_we    = 1'b0;
    lo_re    = 1'b0;
    case (cmd_i.op)
      prb_pkg::OP_ITEM: begin
        if (is_read) begin
          up_re = a15;
          lo_re = !a15;
        end else if (is_load) begin
          if (ld_up) begin
            up_we   = ld_ok;
            up_addr = up_at(ld_bank[BANK_W-1:0], addr);
          end else begin
            lo_we = 1'b1;
          end
        end
      end
      prb_pkg::OP_CLEAR: begin
        up_we    = 1'b1;
        up_addr  = cnt_q;
        up_wdata = prb_pkg::ERASED_BYTE;
      end
      prb_pkg::OP_FILL: begin
        up_we    = 1'b1;
        up_addr  = up_at(fill_bank_q, cnt_q[ROM_AW-1:0]);
        up_wdata = prb_pkg::ERASED_BYTE;
      end
      prb_pkg::OP_STATUS: begin
        up_we    = 1'b1;
        up_addr  = up_at(sel_q, prb_pkg::STATUS_OFFSET);
        up_wdata = prb_pkg::STATUS_OK;
      end
      prb_pkg::OP_BUMP_RD: begin
        up_re   = 1'b1;
        up_addr = up_at(sel_q, prb_pkg::RESP_OFFSET);
      end
      prb_pkg::OP_BUMP_WR: begin
        up_we    = 1'b1;
        up_addr  = up_at(sel_q, prb_pkg::RESP_OFFSET);
        up_wdata = up_rdata + 8'd1;
      end
      default: begin
        up_we = 1'b0;
      end
    endcase
  end

  prb_ram #(
    .WIDTH  (prb_pkg::BYTE_W),
    .DEPTH  (UP_DEPTH),
    .ADDR_W (UP_AW)
  ) u_upper (
    .clk_i   (clk_i),
    .we_i    (up_we),
    .re_i    (up_re),
    .addr_i  (up_addr),
    .wdata_i (up_wdata),
    .rdata_o (up_rdata)
  );

  prb_ram #(
    .WIDTH  (prb_pkg::BYTE_W),
    .DEPTH  (prb_pkg::ROM_BYTES),
    .ADDR_W (ROM_AW)
  ) u_lower (
    .clk_i   (clk_i),
    .we_i    (lo_we),
    .re_i    (lo_re),
    .addr_i  (addr),
    .wdata_i (din),
    .rdata_o (lo_rdata)
  );

  // per-item read routing, then the result register
  logic       drive_q;
  logic       upper_q;
  logic [7:0] rd_q;
  logic       drv_q;
  logic       led_q;

  always_ff @(posedge clk_i) begin
    if (item_en) begin
      drive_q <= is_read && (!a15 || present_q[sel_q]);
      upper_q <= a15;
    end
    if (cmd_i.out_load) begin
      rd_q  <= drive_q ? (upper_q ? up_rdata : lo_rdata) : 8'h00;
      drv_q <= drive_q;
      led_q <= lamp_q;
    end
  end

  assign m_tdata_o = {6'b0, led_q, drv_q, rd_q};

  assign status_o.mode          = mode;
  assign status_o.act_fill      = act_fill;
  assign status_o.act_status    = act_status;
  assign status_o.act_bump      = act_bump;
  assign status_o.cnt_last_all  = (cnt_q == LAST_ALL);
  assign status_o.cnt_last_bank = (cnt_q[ROM_AW-1:0] == LAST_OFF);

endmodule

// File: hw/rtl/prb_ctrl.sv
// controller: sequences item accept, store sweeps, counter update and result hand-off
`include "paged_rom_board_with_command_latch_unit_macros.svh"

module prb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  input  prb_pkg::dp_status_t status_i,
  output prb_pkg::dp_cmd_t    cmd_o
);

  prb_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  always_comb begin
    state_d        = state_q;
    cmd_o.op       = prb_pkg::OP_NONE;
    cmd_o.cnt_clr  = 1'b0;
    cmd_o.out_load = 1'b0;
    s_tready_o     = 1'b0;
    case (state_q)
      prb_pkg::S_INIT: begin
        // erase every upper bank after reset
        cmd_o.op = prb_pkg::OP_CLEAR;
        if (status_i.cnt_last_all) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = prb_pkg::S_IDLE;
        end
      end
      prb_pkg::S_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.op = prb_pkg::OP_ITEM;
          state_d  = prb_pkg::S_DONE;
          if (status_i.mode == prb_pkg::MODE_LATCH) begin
            if (status_i.act_fill) begin
              state_d = prb_pkg::S_FILL;
            end else if (status_i.act_status) begin
              state_d = prb_pkg::S_STATUS;
            end else if (status_i.act_bump) begin
              state_d = prb_pkg::S_BUMP_RD;
            end
          end
        end
      end
      prb_pkg::S_FILL: begin
        cmd_o.op = prb_pkg::OP_FILL;
        if (status_i.cnt_last_bank) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = prb_pkg::S_BUMP_RD;
        end
      end
      prb_pkg::S_STATUS: begin
        cmd_o.op = prb_pkg::OP_STATUS;
        state_d  = prb_pkg::S_BUMP_RD;
      end
      prb_pkg::S_BUMP_RD: begin
        cmd_o.op = prb_pkg::OP_BUMP_RD;
        state_d  = prb_pkg::S_BUMP_WR;
      end
      prb_pkg::S_BUMP_WR: begin
        cmd_o.op = prb_pkg::OP_BUMP_WR;
        state_d  = prb_pkg::S_DONE;
      end
      prb_pkg::S_DONE: begin
        if (!out_valid_q || m_tready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = prb_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = prb_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= prb_pkg::S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_tvalid_o = out_valid_q;

  `PRB_ASSERT(a_load_into_free_slot, cmd_o.out_load |-> (!out_valid_q || m_tready_i), "result register overwritten")
  `PRB_ASSERT_NEXT(a_accept_goes_busy, (s_tvalid_i && s_tready_o), !s_tready_o, "second item taken while busy")
  `PRB_ASSERT_NEXT(a_bump_write_follows, (state_q == prb_pkg::S_BUMP_RD), (state_q == prb_pkg::S_BUMP_WR), "counter update split")
  `PRB_ASSERT_NEXT(a_fill_then_bump, (state_q == prb_pkg::S_FILL && status_i.cnt_last_bank), (state_q == prb_pkg::S_BUMP_RD), "fill did not end in counter update")

endmodule

// File: hw/rtl/paged_rom_board_with_command_latch_unit.sv
// Paged ROM board with command latch. Serves a lower ROM and NUM_BANKS upper
// 16 KB banks to a host bus and decodes latch bytes (bank select, prefixed
// commands). Each input item yields exactly one result item. After reset an
// erase pass writes 0xFF through every upper bank, one byte a cycle, before the
// first item is taken. Afterwards a read, a load, a plain latch byte or a
// command parameter that completes nothing is accepted and then loaded into
// the result register. A completed command other than NOP or an unknown one
// adds a read-modify-write of the response byte through the single port of
// the upper store, preceded by a write of the status byte when that is
// cleared as well; ROMOUT first walks its bank. The result register lets the
// next item be accepted while a result still waits.
module paged_rom_board_with_command_latch_unit #(
  parameter int NUM_BANKS = prb_pkg::NUM_BANKS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // rom_enable_n, a15, address[13:0], data_in[7:0], load_upper, load_bank[3:0], zero pad
  input  logic [prb_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // mode[1:0]
  input  logic [prb_pkg::IN_TUSER_W-1:0]    s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // read_data[7:0], drive_bus, led_on, zero pad
  output logic [prb_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o
);

  prb_pkg::dp_cmd_t    cmd;
  prb_pkg::dp_status_t status;

  prb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  prb_datapath #(
    .NUM_BANKS (NUM_BANKS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .status_o  (status),
    .s_tdata_i (s_axis_tdata_i),
    .s_tuser_i (s_axis_tuser_i),
    .m_tdata_o (m_axis_tdata_o)
  );

endmodule

// File: tb/tb_paged_rom_board_with_command_latch_unit.sv
// testbench for the paged rom board: directed and random bus, latch and load items
`timescale 1ns / 1ps

module tb_paged_rom_board_with_command_latch_unit;

  localparam int NBANKS         = prb_pkg::NUM_BANKS_DEF;
  localparam int RANDOM_ITEMS   = 1750;
  localparam int WATCHDOG_LIMIT = 1048576;
  localparam int ROMOUT_BUDGET  = 10;

  typedef struct packed {
    logic [3:0]                 load_bank;
    logic                       load_upper;
    logic [7:0]                 data_in;
    logic [prb_pkg::ROM_AW-1:0] address;
    logic                       a15;
    logic                       rom_enable_n;
  } bus_item_t;

  typedef struct packed {
    logic       led_on;
    logic       drive_bus;
    logic [7:0] read_data;
  } bus_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  // rom_enable_n, a15, address[13:0], data_in[7:0], load_upper, load_bank[3:0], zero pad
  logic [prb_pkg::IN_TDATA_W-1:0] s_axis_tdata_i = '0;
  // mode[1:0]
  logic [prb_pkg::IN_TUSER_W-1:0] s_axis_tuser_i = prb_pkg::MODE_NOP;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  // read_data[7:0], drive_bus, led_on, zero pad
  logic [prb_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o;

  paged_rom_board_with_command_latch_unit #(
    .NUM_BANKS(NBANKS)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i(s_axis_tdata_i),
    .s_axis_tuser_i(s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o(m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // board image kept alongside the dut
  logic [7:0]        low_image [prb_pkg::ROM_BYTES];
  bit                lower_seen [prb_pkg::ROM_BYTES];
  logic [7:0]        upper_rom [NBANKS][prb_pkg::ROM_BYTES];
  bit                bank_on [NBANKS];
  logic [3:0]        cur_bank;
  prb_pkg::phase_e   latch_state;
  logic [7:0]        cur_cmd;
  int                args_left;
  logic              lamp_on;

  bus_result_t                pending_bus_results[$];
  logic [prb_pkg::ROM_AW-1:0] lower_addrs[$];
  logic [prb_pkg::ROM_AW-1:0] hot_addr;
  int                items_sent;
  int                errors;
  int                idle_cycles;
  int                stall_left;
  int                romouts_left;
  bit                quiet;

  function automatic logic [3:0] clamp_bank(logic [7:0] b);
    return (b >= NBANKS) ? 4'(NBANKS - 1) : b[3:0];
  endfunction

  function automatic void bump_response();
    upper_rom[cur_bank][prb_pkg::RESP_OFFSET] =
      upper_rom[cur_bank][prb_pkg::RESP_OFFSET] + 8'd1;
  endfunction

  function automatic void complete_command(logic [7:0] last);
    logic [3:0] b;
    case (cur_cmd)
      prb_pkg::CMD_BANK_IN: begin
        b = clamp_bank(last);
        bank_on[b] = 1'b1;
        bump_response();
      end
      prb_pkg::CMD_BANK_OUT: begin
        b = clamp_bank(last);
        bank_on[b] = 1'b0;
        for (int i = 0; i < prb_pkg::ROM_BYTES; i++) upper_rom[b][i] = prb_pkg::ERASED_BYTE;
        bump_response();
      end
      prb_pkg::CMD_LED: begin
        lamp_on = (last != 8'd0);
        upper_rom[cur_bank][prb_pkg::STATUS_OFFSET] = prb_pkg::STATUS_OK;
        bump_response();
      end
      prb_pkg::CMD_OPT_RESET: begin
        upper_rom[cur_bank][prb_pkg::STATUS_OFFSET] = prb_pkg::STATUS_OK;
        bump_response();
      end
      prb_pkg::CMD_OPT_LOAD, prb_pkg::CMD_OPT_SAVE: bump_response();
      default: ;
    endcase
    latch_state = prb_pkg::PHASE_IDLE;
    cur_cmd = prb_pkg::CMD_NOP;
    args_left = 0;
  endfunction

  function automatic void latch_byte(logic [7:0] v);
    case (latch_state)
      prb_pkg::PHASE_IDLE: begin
        if (v == prb_pkg::PREFIX_BYTE) latch_state = prb_pkg::PHASE_PREFIX;
        else if (v < prb_pkg::IGN_FIRST) cur_bank = (v >= NBANKS) ? 4'd0 : v[3:0];
      end
      prb_pkg::PHASE_PREFIX: begin
        cur_cmd = v;
        args_left = 0;
        latch_state = prb_pkg::PHASE_PARAMS;
        case (v)
          prb_pkg::CMD_NOP: latch_state = prb_pkg::PHASE_IDLE;
          prb_pkg::CMD_SIMPLE_A, prb_pkg::CMD_SIMPLE_B, prb_pkg::CMD_SIMPLE_C,
          prb_pkg::CMD_SIMPLE_D, prb_pkg::CMD_USB: begin
            bump_response();
            latch_state = prb_pkg::PHASE_IDLE;
            cur_cmd = prb_pkg::CMD_NOP;
          end
          prb_pkg::CMD_BANK_IN: args_left = 2;
          prb_pkg::CMD_BANK_OUT, prb_pkg::CMD_LED, prb_pkg::CMD_OPT_LOAD,
          prb_pkg::CMD_OPT_SAVE, prb_pkg::CMD_OPT_RESET: args_left = 1;
          default: ; // unknown command swallows one more byte
        endcase
      end
      default: begin
        if (args_left > 0) args_left--;
        if (args_left == 0) complete_command(v);
      end
    endcase
  endfunction

  function automatic bus_result_t board_result(prb_pkg::mode_e m, bus_item_t f);
    bus_result_t r;
    r = '0;
    case (m)
      prb_pkg::MODE_READ: begin
        if (!f.rom_enable_n) begin
          if (f.a15) begin
            if (bank_on[cur_bank]) begin
              r.read_data = upper_rom[cur_bank][f.address];
              r.drive_bus = 1'b1;
            end
          end else begin
            r.read_data = low_image[f.address];
            r.drive_bus = 1'b1;
          end
        end
      end
      prb_pkg::MODE_LATCH: latch_byte(f.data_in);
      prb_pkg::MODE_LOAD: begin
        if (f.load_upper) begin
          if (f.load_bank < NBANKS) begin
            upper_rom[f.load_bank][f.address] = f.data_in;
            bank_on[f.load_bank] = 1'b1;
            hot_addr = f.address;
          end
        end else begin
          if (!lower_seen[f.address]) lower_addrs.push_back(f.address);
          low_image[f.address] = f.data_in;
          lower_seen[f.address] = 1'b1;
        end
      end
      default: ;
    endcase
    r.led_on = lamp_on;
    return r;
  endfunction

  task automatic flag_mismatch(string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  task automatic send_item(prb_pkg::mode_e m, bus_item_t f);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= prb_pkg::IN_TDATA_W'(f);
    s_axis_tuser_i  <= m;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_bus_results.push_back(board_result(m, f));
    if (m != prb_pkg::MODE_NOP) items_sent++;
  endtask

  task automatic hold_until_drained();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_bus_results.size() > 0) @(posedge clk_i);
  endtask

  function automatic bus_item_t rand_fields();
    bus_item_t f;
    f = bus_item_t'($urandom_range(0, (1 << 29) - 1));
    return f;
  endfunction

  function automatic logic [prb_pkg::ROM_AW-1:0] pick_addr();
    case ($urandom_range(0, 4))
      0: return prb_pkg::RESP_OFFSET;
      1: return prb_pkg::STATUS_OFFSET;
      2: return hot_addr;
      default: return prb_pkg::ROM_AW'($urandom_range(0, prb_pkg::ROM_BYTES - 1));
    endcase
  endfunction

  task automatic send_read(logic en_n, logic hi, logic [prb_pkg::ROM_AW-1:0] addr);
    bus_item_t f;
    f = rand_fields();
    f.rom_enable_n = en_n;
    f.a15 = hi;
    f.address = addr;
    send_item(prb_pkg::MODE_READ, f);
  endtask

  task automatic send_load(logic up, logic [3:0] bank, logic [prb_pkg::ROM_AW-1:0] addr,
                           logic [7:0] val);
    bus_item_t f;
    f = rand_fields();
    f.load_upper = up;
    f.load_bank = bank;
    f.address = addr;
    f.data_in = val;
    send_item(prb_pkg::MODE_LOAD, f);
  endtask

  task automatic send_latch(logic [7:0] val);
    bus_item_t f;
    f = rand_fields();
    f.data_in = val;
    send_item(prb_pkg::MODE_LATCH, f);
  endtask

  task automatic random_read();
    bus_item_t f;
    f = rand_fields();
    f.rom_enable_n = ($urandom_range(0, 4) == 0);
    f.address = pick_addr();
    // lower bytes are only read once loaded
    if (!f.rom_enable_n && !f.a15) begin
      if (lower_addrs.size() == 0) f.rom_enable_n = 1'b1;
      else f.address = lower_addrs[$urandom_range(0, lower_addrs.size() - 1)];
    end
    send_item(prb_pkg::MODE_READ, f);
  endtask

  task automatic random_load();
    bus_item_t f;
    f = rand_fields();
    if ($urandom_range(0, 1) == 0) f.address = pick_addr();
    if (f.load_upper)
      f.load_bank = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(NBANKS, 15))
                                                : 4'($urandom_range(0, NBANKS - 1));
    send_item(prb_pkg::MODE_LOAD, f);
  endtask

  function automatic logic [7:0] bank_arg();
    return ($urandom_range(0, 5) == 0) ? 8'($urandom_range(NBANKS, 255))
                                       : 8'($urandom_range(0, NBANKS - 1));
  endfunction

  task automatic maybe_interleave();
    case ($urandom_range(0, 9))
      0: random_read();
      1: random_load();
      default: ;
    endcase
  endtask

  task automatic random_command();
    logic [7:0] op;
    case ($urandom_range(0, 12))
      0: op = prb_pkg::CMD_NOP;
      1: op = prb_pkg::CMD_SIMPLE_A;
      2: op = prb_pkg::CMD_SIMPLE_B;
      3: op = prb_pkg::CMD_SIMPLE_C;
      4: op = prb_pkg::CMD_SIMPLE_D;
      5: op = prb_pkg::CMD_USB;
      6: op = prb_pkg::CMD_BANK_IN;
      7: op = (romouts_left > 0) ? prb_pkg::CMD_BANK_OUT : prb_pkg::CMD_LED;
      8: op = prb_pkg::CMD_LED;
      9: op = prb_pkg::CMD_OPT_RESET;
      10: op = prb_pkg::CMD_OPT_LOAD;
      11: op = prb_pkg::CMD_OPT_SAVE;
      default: op = 8'($urandom_range(8'h20, 8'hF9));
    endcase
    send_latch(prb_pkg::PREFIX_BYTE);
    maybe_interleave();
    send_latch(op);
    case (op)
      prb_pkg::CMD_NOP, prb_pkg::CMD_SIMPLE_A, prb_pkg::CMD_SIMPLE_B,
      prb_pkg::CMD_SIMPLE_C, prb_pkg::CMD_SIMPLE_D, prb_pkg::CMD_USB: ;
      prb_pkg::CMD_BANK_IN: begin
        send_latch(8'($urandom_range(0, 255)));
        maybe_interleave();
        send_latch(bank_arg());
      end
      prb_pkg::CMD_BANK_OUT: begin
        romouts_left--;
        maybe_interleave();
        send_latch(bank_arg());
      end
      prb_pkg::CMD_LED: begin
        maybe_interleave();
        send_latch($urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(0, 255)));
      end
      default: begin
        maybe_interleave();
        send_latch(8'($urandom_range(0, 255)));
      end
    endcase
    if ($urandom_range(0, 1) == 0) send_read(1'b0, 1'b1, prb_pkg::RESP_OFFSET);
  endtask

  task automatic test_rom_loads();
    send_load(1'b0, 4'd0, '0, 8'h00);
    send_load(1'b0, 4'd0, '1, 8'hFF);
    send_load(1'b1, 4'(NBANKS - 1), '1, 8'hA5);
    send_load(1'b1, 4'hF, '0, 8'h12); // out-of-range bank is dropped
  endtask

  task automatic test_bus_reads();
    send_read(1'b0, 1'b0, '0);
    send_read(1'b0, 1'b0, '1);
    send_read(1'b1, 1'b0, '1);
    send_read(1'b0, 1'b1, '1); // bank 0 absent, bus left floating
  endtask

  task automatic test_bank_select();
    send_latch(8'(NBANKS - 1));
    send_read(1'b0, 1'b1, '1);
    send_latch(8'd200); // out of range falls back to bank 0
    send_latch(prb_pkg::IGN_FIRST);
    send_read(1'b0, 1'b1, '1);
  endtask

  task automatic test_commands();
    send_latch(8'(NBANKS - 1));
    send_latch(prb_pkg::PREFIX_BYTE);
    send_latch(prb_pkg::CMD_LED);
    send_latch(8'h01);
    send_read(1'b0, 1'b1, prb_pkg::RESP_OFFSET);
    send_latch(prb_pkg::PREFIX_BYTE);
    send_latch(prb_pkg::CMD_BANK_IN);
    send_latch(8'h03);
    send_latch(8'h20);
    // unknown command eats the following byte
    send_latch(prb_pkg::PREFIX_BYTE);
    send_latch(8'h55);
    send_latch(8'h77);
    send_item(prb_pkg::MODE_NOP, rand_fields());
    send_latch(prb_pkg::PREFIX_BYTE);
    send_latch(prb_pkg::CMD_BANK_OUT);
    send_latch(8'h0F);
    send_read(1'b0, 1'b1, '1);
  endtask

  task automatic test_random_traffic();
    int goal;
    int pick;
    bit paused;
    goal = items_sent + RANDOM_ITEMS;
    paused = 1'b0;
    while (items_sent < goal) begin
      quiet = (items_sent + 250 >= goal) || ((items_sent / 128) % 4 == 3);
      if (!paused && items_sent * 2 >= goal) begin
        hold_until_drained();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 19);
      if (pick < 6) random_read();
      else if (pick < 9) random_load();
      else if (pick < 16) random_command();
      else if (pick < 18)
        send_latch(($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, NBANKS - 1)));
      else if (pick < 19) send_item(prb_pkg::MODE_NOP, rand_fields());
      else send_read(1'b0, 1'b1, pick_addr());
    end
  endtask

  // result checker
  always @(posedge clk_i) begin : check_results
    bus_result_t want;
    bus_result_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[9:0];
      if (pending_bus_results.size() == 0) begin
        flag_mismatch($sformatf("result %h with nothing outstanding", got));
      end else begin
        want = pending_bus_results.pop_front();
        if (got.read_data !== want.read_data)
          flag_mismatch($sformatf("read_data %h, wanted %h", got.read_data, want.read_data));
        if (got.drive_bus !== want.drive_bus)
          flag_mismatch($sformatf("drive_bus %b, wanted %b", got.drive_bus, want.drive_bus));
        if (got.led_on !== want.led_on)
          flag_mismatch($sformatf("led_on %b, wanted %b", got.led_on, want.led_on));
      end
    end
  end

  // result side backpressure
  always @(negedge clk_i) begin
    if (!quiet && stall_left == 0 && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 7);
    if (stall_left > 0) begin
      m_axis_tready_i <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // idle watchdog, whose limit covers the erase pass after reset and a full bank fill
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    errors = 0;
    items_sent = 0;
    quiet = 1'b0;
    romouts_left = ROMOUT_BUDGET;
    hot_addr = '0;
    cur_bank = '0;
    latch_state = prb_pkg::PHASE_IDLE;
    cur_cmd = prb_pkg::CMD_NOP;
    args_left = 0;
    lamp_on = 1'b0;
    for (int b = 0; b < NBANKS; b++) begin
      bank_on[b] = 1'b0;
      for (int i = 0; i < prb_pkg::ROM_BYTES; i++) upper_rom[b][i] = prb_pkg::ERASED_BYTE;
    end
    for (int i = 0; i < prb_pkg::ROM_BYTES; i++) begin
      low_image[i] = 8'h00;
      lower_seen[i] = 1'b0;
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_rom_loads();
    test_bus_reads();
    test_bank_select();
    test_commands();
    test_random_traffic();

    hold_until_drained();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/prb_pkg.sv
hw/rtl/prb_ram.sv
hw/rtl/prb_datapath.sv
hw/rtl/prb_ctrl.sv
hw/rtl/paged_rom_board_with_command_latch_unit.sv
tb/tb_paged_rom_board_with_command_latch_unit.sv
